[rtl/bss_pkg.sv]
`timescale 1ns / 1ps
package bss_pkg;

  // width of the segment length config field
  localparam int CFG_W = 6;
  // samples per segment after reset
  localparam int RESET_SAMPLES = 20;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // latch the incoming waypoint
    logic shift;     // shift the waypoint window
    logic shift_in;  // shift source is the input port, else the latched point
    logic setup;     // build control points, restart the t accumulator
    logic seg2;      // segment that ends at the new waypoint
    logic full;      // previous neighbor exists in the window
    logic issue;     // start one sample down the pipeline
    logic run_end;   // sample issued is the last one for this word
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic adv;       // pipeline advances this cycle
  } dp_sts_t;

endpackage

[rtl/bss_ifs.sv]
`timescale 1ns / 1ps
interface bss_pt_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          is_last_point;

  modport source(output valid, output point_x, output point_y, output is_last_point,
                 input ready);
  modport sink(input valid, input point_x, input point_y, input is_last_point,
               output ready);
endinterface

interface bss_crv_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] curve_x;
  logic signed [COORD_WIDTH-1:0] curve_y;
  logic                          run_end;

  modport source(output valid, output curve_x, output curve_y, output run_end,
                 input ready);
  modport sink(input valid, input curve_x, input curve_y, input run_end,
               output ready);
endinterface

interface bss_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bss_pkg::CFG_W-1:0]    seg_samples;

  modport source(output valid, output seg_samples, input ready);
  modport sink(input valid, input seg_samples, output ready);
endinterface

[rtl/bss_ctrl.sv]
`timescale 1ns / 1ps
module bss_ctrl #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_last,
  output logic                               in_ready,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0]   samples,
  output bss_pkg::dp_cmd_t                   cmd,
  input  bss_pkg::dp_sts_t                   sts
);
  import bss_pkg::*;

  localparam int NCW = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic [1:0]     pts_r, pts_nxt;
  logic           seg2_r, seg2_nxt;
  logic           full_r, full_nxt;
  logic           pend2_r, pend2_nxt;
  logic [NCW-1:0] cnt_r, cnt_nxt;
  logic           last_seg;
  logic           cnt_done;
  logic           has1, has2;

  assign last_seg = seg2_r || !pend2_r;
  assign cnt_done = (cnt_r == samples - NCW'(1));
  assign has1     = (pts_r >= 2'd2);
  assign has2     = in_last && (pts_r != 2'd0);
  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    pts_nxt   = pts_r;
    seg2_nxt  = seg2_r;
    full_nxt  = full_r;
    pend2_nxt = pend2_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_last) pts_nxt = 2'd0;
          else if (pts_r != 2'd3) pts_nxt = pts_r + 2'd1;
          if (has1) begin
            seg2_nxt  = 1'b0;
            full_nxt  = (pts_r == 2'd3);
            pend2_nxt = has2;
            state_nxt = ST_SETUP;
          end else if (has2) begin
            seg2_nxt  = 1'b1;
            full_nxt  = 1'b0;
            pend2_nxt = 1'b0;
            state_nxt = ST_SETUP;
          end else begin
            // no segment: window takes the point straight from the port
            cmd.shift    = 1'b1;
            cmd.shift_in = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        cmd.seg2  = seg2_r;
        cmd.full  = full_r;
        // window is free once the last control points are built
        cmd.shift = last_seg;
        cnt_nxt   = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.issue   = sts.adv;
        cmd.run_end = last_seg && cnt_done;
        if (sts.adv) begin
          cnt_nxt = cnt_r + NCW'(1);
          if (cnt_done) begin
            if (!last_seg) begin
              seg2_nxt  = 1'b1;
              full_nxt  = 1'b1;
              pend2_nxt = 1'b0;
              state_nxt = ST_SETUP;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pts_r   <= '0;
      seg2_r  <= 1'b0;
      full_r  <= 1'b0;
      pend2_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pts_r   <= pts_nxt;
      seg2_r  <= seg2_nxt;
      full_r  <= full_nxt;
      pend2_r <= pend2_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[rtl/bss_datapath.sv]
`timescale 1ns / 1ps
module bss_datapath #(
  parameter int COORD_WIDTH = 32,
  parameter int MAX_SAMPLES = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bss_pkg::dp_cmd_t                   cmd,
  output bss_pkg::dp_sts_t                   sts,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0]   samples,
  input  logic signed [COORD_WIDTH-1:0]      pt_x,
  input  logic signed [COORD_WIDTH-1:0]      pt_y,
  bss_crv_if.source                          out_crv
);
  import bss_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int CW  = COORD_WIDTH + 3;   // control points are kept times 4
  localparam int NCW = $clog2(MAX_SAMPLES + 1);
  localparam int IW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  // sign extend a coordinate to control point width
  function automatic logic signed [CW-1:0] ext(input logic signed [W-1:0] v);
    ext = {{3{v[W-1]}}, v};
  endfunction

  // a + floor((b - a) * t / 65536)
  function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic [15:0] t);
    logic signed [CW:0]    d;
    logic signed [CW+17:0] p;
    logic signed [CW+17:0] ps;
    d    = {b[CW-1], b} - {a[CW-1], a};
    p    = d * $signed({1'b0, t});
    ps   = p >>> 16;
    lerp = a + $signed(ps[CW-1:0]);
  endfunction

  // floor(65536 / n) and 65536 mod n, per n
  logic [16:0]    rq_tab [2**IW];
  logic [NCW-1:0] rr_tab [2**IW];
  for (genvar g = 0; g < 2**IW; g++) begin : g_recip
    localparam int RQ = 65536 / (g + 1);
    localparam int RR = 65536 % (g + 1);
    assign rq_tab[g] = 17'(RQ);
    assign rr_tab[g] = NCW'(RR);
  end

  logic signed [W-1:0]  win_x_r [3];
  logic signed [W-1:0]  win_y_r [3];
  logic signed [W-1:0]  nx_r, ny_r;
  logic signed [CW-1:0] cp_r  [2][4];
  logic signed [CW-1:0] s1_r  [2][3];
  logic signed [CW-1:0] s2_r  [2][2];
  logic signed [CW-1:0] s3_r  [2];
  logic [16:0]          q_r, q_nxt;
  logic [NCW-1:0]       rem_r, rem_nxt;
  logic [15:0]          t1_r, t2_r;
  logic                 v1_r, v2_r, v3_r, ov_r;
  logic                 re1_r, re2_r, re3_r, ore_r;
  logic signed [W-1:0]  ox_r, oy_r;
  logic                 adv;

  assign adv     = !ov_r || out_crv.ready;
  assign sts.adv = adv;

  // waypoint latch and window
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      nx_r <= pt_x;
      ny_r <= pt_y;
    end
    if (cmd.shift) begin
      win_x_r[0] <= win_x_r[1];
      win_y_r[0] <= win_y_r[1];
      win_x_r[1] <= win_x_r[2];
      win_y_r[1] <= win_y_r[2];
      win_x_r[2] <= cmd.shift_in ? pt_x : nx_r;
      win_y_r[2] <= cmd.shift_in ? pt_y : ny_r;
    end
  end

  // control points of the segment
  logic signed [W-1:0] prv [2], p0 [2], p3 [2], nxt [2];
  always_comb begin
    if (cmd.seg2) begin
      prv[0] = cmd.full ? win_x_r[1] : win_x_r[2];
      prv[1] = cmd.full ? win_y_r[1] : win_y_r[2];
      p0[0]  = win_x_r[2];
      p0[1]  = win_y_r[2];
      p3[0]  = nx_r;
      p3[1]  = ny_r;
    end else begin
      prv[0] = cmd.full ? win_x_r[0] : win_x_r[1];
      prv[1] = cmd.full ? win_y_r[0] : win_y_r[1];
      p0[0]  = win_x_r[1];
      p0[1]  = win_y_r[1];
      p3[0]  = win_x_r[2];
      p3[1]  = win_y_r[2];
    end
    nxt[0] = nx_r;
    nxt[1] = ny_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      for (int a = 0; a < 2; a++) begin
        cp_r[a][0] <= ext(p0[a]) <<< 2;
        cp_r[a][1] <= (ext(p0[a]) <<< 2) + ext(p3[a]) - ext(prv[a]);
        cp_r[a][2] <= (ext(p3[a]) <<< 2) - ext(nxt[a]) + ext(p0[a]);
        cp_r[a][3] <= ext(p3[a]) <<< 2;
      end
    end
  end

  // t = floor(s * 65536 / n), stepped by quotient and remainder
  logic [NCW-1:0] nm1;
  logic [IW-1:0]  idx;
  logic [NCW:0]   rsum;
  logic           wrap;
  always_comb begin
    nm1     = samples - NCW'(1);
    idx     = nm1[IW-1:0];
    rsum    = {1'b0, rem_r} + {1'b0, rr_tab[idx]};
    wrap    = (rsum >= {1'b0, samples});
    q_nxt   = q_r + rq_tab[idx] + 17'(wrap);
    rem_nxt = wrap ? NCW'(rsum - {1'b0, samples}) : rsum[NCW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r   <= '0;
      rem_r <= '0;
    end else if (cmd.setup) begin
      q_r   <= '0;
      rem_r <= '0;
    end else if (cmd.issue) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  // de casteljau pipeline, one level per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        s1_r[a][0] <= lerp(cp_r[a][0], cp_r[a][1], q_r[15:0]);
        s1_r[a][1] <= lerp(cp_r[a][1], cp_r[a][2], q_r[15:0]);
        s1_r[a][2] <= lerp(cp_r[a][2], cp_r[a][3], q_r[15:0]);
        s2_r[a][0] <= lerp(s1_r[a][0], s1_r[a][1], t1_r);
        s2_r[a][1] <= lerp(s1_r[a][1], s1_r[a][2], t1_r);
        s3_r[a]    <= lerp(s2_r[a][0], s2_r[a][1], t2_r);
      end
      t1_r  <= q_r[15:0];
      t2_r  <= t1_r;
      re1_r <= cmd.run_end;
      re2_r <= re1_r;
      re3_r <= re2_r;
      ore_r <= re3_r;
    end
  end

  // divide by 4 with floor and saturate
  function automatic logic signed [W-1:0] sat(input logic signed [CW-1:0] v);
    logic signed [W:0] sh;
    sh = v[CW-1:2];
    if (sh[W] != sh[W-1]) sat = sh[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else sat = sh[W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= sat(s3_r[0]);
      oy_r <= sat(s3_r[1]);
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      ov_r <= v3_r;
    end
  end

  assign out_crv.valid   = ov_r;
  assign out_crv.curve_x = ox_r;
  assign out_crv.curve_y = oy_r;
  assign out_crv.run_end = ore_r;

endmodule

[rtl/bezier_spline_sampler_core.sv]
`timescale 1ns / 1ps
// Cubic Bezier spline sampler for 2-D waypoints (signed Q16.16).
// in_pt takes one waypoint word at a time; is_last_point ends the path.
// out_crv gives the curve samples; run_end marks the last sample caused by
// one input word. cfg_ch writes the samples per segment N (0 reads as 1,
// values above MAX_SAMPLES as MAX_SAMPLES); write it only while the block is idle.
// From the third waypoint on each word releases one segment of N samples,
// a last word releases up to two. A lone last point gives nothing.
// Flow: a word is taken while idle, each segment then passes a setup state
// and issues one sample per cycle while out_crv does not stall. The sample
// pipeline (three lerp stages and an output register) holds the samples in
// flight; the next word is taken while it drains.
// Reset clears the waypoint count, the pipeline and sets N to 20.
// A stalled out_crv holds its word and freezes the pipeline and the
// sample issue until it is taken.
module bezier_spline_sampler_core #(
  parameter int COORD_WIDTH = 32,
  parameter int MAX_SAMPLES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  bss_pt_if.sink    in_pt,
  bss_crv_if.source out_crv,
  bss_cfg_if.sink   cfg_ch
);
  import bss_pkg::*;

  localparam int NCW   = $clog2(MAX_SAMPLES + 1);
  localparam int RST_N = (RESET_SAMPLES > MAX_SAMPLES) ? MAX_SAMPLES : RESET_SAMPLES;

  logic [NCW-1:0] n_r, n_nxt;
  dp_cmd_t        cmd;
  dp_sts_t        sts;

  // samples per segment register, clamped on write
  assign cfg_ch.ready = 1'b1;
  always_comb begin
    if (cfg_ch.seg_samples == '0) n_nxt = NCW'(1);
    else if (32'(cfg_ch.seg_samples) > 32'(MAX_SAMPLES)) n_nxt = NCW'(MAX_SAMPLES);
    else n_nxt = NCW'(cfg_ch.seg_samples);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) n_r <= NCW'(RST_N);
    else if (cfg_ch.valid) n_r <= n_nxt;
  end

  bss_ctrl #(.MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pt.valid),
    .in_last  (in_pt.is_last_point),
    .in_ready (in_pt.ready),
    .samples  (n_r),
    .cmd      (cmd),
    .sts      (sts)
  );

  bss_datapath #(.COORD_WIDTH(COORD_WIDTH), .MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .samples (n_r),
    .pt_x    (in_pt.point_x),
    .pt_y    (in_pt.point_y),
    .out_crv (out_crv)
  );

  // a sample is issued only when the pipeline moves
  a_issue_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> sts.adv) else $error("sample issued into a stalled pipeline");

  // no sample issue in the cycle a word is taken
  a_accept_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !cmd.issue) else $error("issue while taking a word");

  // output valid only rises on a pipeline advance
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_crv.valid) |-> $past(sts.adv)) else $error("output rose without advance");

endmodule

[bench/bss_tb_pkg.sv]
`timescale 1ns / 1ps
package bss_tb_pkg;

  // one expected curve sample
  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               last;
  } sample_t;

endpackage

[bench/bss_spline_checker.sv]
`timescale 1ns / 1ps
module bss_spline_checker (
  input  logic      clk,
  input  logic      rst_n,
  bss_pt_if.sink    in_pt,
  bss_crv_if.sink   out_crv,
  bss_cfg_if.sink   cfg_ch,
  output int        fail_count,
  output int        pending_samples,
  output int        samples_seen
);
  import bss_tb_pkg::*;

  sample_t       curve_q[$];
  longint        win_x[3];
  longint        win_y[3];
  int unsigned   held_pts;
  int unsigned   seg_len;
  int            word_idx;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  // floor((b - a) * t / 65536) added to a
  function automatic longint lerp16(input longint a, input longint b, input longint t);
    longint d;
    d = (b - a) * t;
    return a + (d >>> 16);
  endfunction

  function automatic logic signed [31:0] eval_curve(input longint c0, input longint c1,
                                                    input longint c2, input longint c3,
                                                    input longint t);
    longint a, b, e, f, g, v;
    a = lerp16(c0, c1, t);
    b = lerp16(c1, c2, t);
    e = lerp16(c2, c3, t);
    f = lerp16(a, b, t);
    g = lerp16(b, e, t);
    v = lerp16(f, g, t) >>> 2;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // queue samples of segment p0 -> p3 with neighbors pv, nx
  task automatic push_segment(input longint pvx, input longint p0x, input longint p3x,
                              input longint nxx, input longint pvy, input longint p0y,
                              input longint p3y, input longint nxy);
    longint t;
    sample_t smp;
    for (int s = 0; s < seg_len; s++) begin
      t = (longint'(s) << 16) / seg_len;
      smp.cx = eval_curve(4*p0x, 4*p0x + p3x - pvx, 4*p3x - nxx + p0x, 4*p3x, t);
      smp.cy = eval_curve(4*p0y, 4*p0y + p3y - pvy, 4*p3y - nxy + p0y, 4*p3y, t);
      smp.last = 1'b0;
      curve_q.insert(curve_q.size(), smp);
    end
  endtask

  // window update and segment release per accepted waypoint word
  task automatic predict_word(input longint x, input longint y, input logic is_last);
    int q_start;
    int ip;
    q_start = curve_q.size();
    if (held_pts >= 2) begin
      ip = (held_pts >= 3) ? 0 : 1;
      push_segment(win_x[ip], win_x[1], win_x[2], x, win_y[ip], win_y[1], win_y[2], y);
    end
    if (is_last && held_pts >= 1) begin
      ip = (held_pts >= 2) ? 1 : 2;
      push_segment(win_x[ip], win_x[2], x, x, win_y[ip], win_y[2], y, y);
    end
    if (curve_q.size() > q_start) curve_q[$].last = 1'b1;
    win_x[0] = win_x[1]; win_y[0] = win_y[1];
    win_x[1] = win_x[2]; win_y[1] = win_y[2];
    win_x[2] = x;        win_y[2] = y;
    if (is_last) held_pts = 0;
    else if (held_pts < 3) held_pts++;
  endtask

  always @(posedge clk) begin
    sample_t exp_s;
    int unsigned v;
    if (!rst_n) begin
      held_pts = 0;
      seg_len = 20;
      fail_count = 0;
      samples_seen = 0;
      word_idx = 0;
      curve_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        v = cfg_ch.seg_samples;
        seg_len = (v == 0) ? 1 : (v > 32 ? 32 : v);
      end
      if (out_crv.valid && out_crv.ready) begin
        samples_seen++;
        if (curve_q.size() == 0) begin
          report_mismatch("curve sample with none expected");
        end else begin
          exp_s = curve_q.pop_front();
          if (out_crv.curve_x !== exp_s.cx)
            report_mismatch($sformatf("curve_x %0d want %0d", out_crv.curve_x, exp_s.cx));
          if (out_crv.curve_y !== exp_s.cy)
            report_mismatch($sformatf("curve_y %0d want %0d", out_crv.curve_y, exp_s.cy));
          if (out_crv.run_end !== exp_s.last)
            report_mismatch($sformatf("run_end %0b want %0b", out_crv.run_end, exp_s.last));
        end
      end
      if (in_pt.valid && in_pt.ready) begin
        predict_word(longint'(in_pt.point_x), longint'(in_pt.point_y), in_pt.is_last_point);
        word_idx++;
      end
    end
    pending_samples = curve_q.size();
  end

endmodule

[bench/bezier_spline_sampler_core_tb.sv]
`timescale 1ns / 1ps
module bezier_spline_sampler_core_tb;

  localparam longint CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_samples;
  int   samples_seen;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_off;
  int   stall_len;
  int   stall_reqs;
  int   stall_seen;
  int   words_sent;
  longint cycle_cnt;
  bit   cfg_hit[6];

  bss_pt_if  #(.COORD_WIDTH(32)) in_pt ();
  bss_crv_if #(.COORD_WIDTH(32)) out_crv ();
  bss_cfg_if                     cfg_ch ();

  bezier_spline_sampler_core #(.COORD_WIDTH(32), .MAX_SAMPLES(32)) dut (
    .clk(clk), .rst_n(rst_n), .in_pt(in_pt.sink), .out_crv(out_crv.source),
    .cfg_ch(cfg_ch.sink)
  );

  bss_spline_checker chk (
    .clk(clk), .rst_n(rst_n), .in_pt(in_pt.sink), .out_crv(out_crv.sink),
    .cfg_ch(cfg_ch.sink), .fail_count(fail_count), .pending_samples(pending_samples),
    .samples_seen(samples_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_crv.ready <= 1'b0;
      hold_off <= 0;
      stall_seen <= 0;
    end else if (stall_seen != stall_reqs) begin
      stall_seen <= stall_reqs;
      hold_off <= stall_len;
      out_crv.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_crv.ready <= 1'b0;
    end else begin
      out_crv.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // send one waypoint word, with a random idle gap after it
  task automatic send_word(input logic [31:0] x, input logic [31:0] y, input logic lst);
    in_pt.valid <= 1'b1;
    in_pt.point_x <= x;
    in_pt.point_y <= y;
    in_pt.is_last_point <= lst;
    @(posedge clk);
    while (!in_pt.ready) @(posedge clk);
    words_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_pt.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_pt.valid <= 1'b0;
    @(posedge clk);
    while (pending_samples != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_len(input logic [5:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.seg_samples <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return {{12{$urandom_range(1) == 1}}, 20'($urandom())};
    endcase
  endfunction

  // a path of plen words, the last one flagged
  task automatic send_path(input int plen);
    for (int i = 0; i < plen; i++) send_word(rand_coord(), rand_coord(), i == plen - 1);
  endtask

  initial begin
    rst_n = 1'b0;
    stall_len = 0;
    stall_reqs = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    words_sent = 0;
    in_pt.valid = 1'b0;
    in_pt.point_x = '0;
    in_pt.point_y = '0;
    in_pt.is_last_point = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.seg_samples = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lone point, two points, extremes, reset length
    send_idle_pct = 38; recv_idle_pct = 65;
    send_word(32'h12345678, 32'h87654321, 1'b1);
    send_word(32'h7fffffff, 32'h80000000, 1'b0);
    send_word(32'h80000000, 32'h7fffffff, 1'b1);
    send_word(32'h80000000, 32'h80000000, 1'b0);
    send_word(32'h7fffffff, 32'h7fffffff, 1'b0);
    send_word(32'h80000000, 32'h80000000, 1'b0);
    send_word(32'h7fffffff, 32'h00000000, 1'b0);
    send_word(32'h00000000, 32'hffffffff, 1'b1);
    // register extremes: zero, one, max, above max
    foreach (cfg_hit[k]) begin
      write_len(k == 0 ? 6'd0 : k == 1 ? 6'd1 : k == 2 ? 6'd32 : k == 3 ? 6'd63 : 6'd2);
      send_path(k == 5 ? 2 : 4);
    end

    // random paths through the three idle profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 65 : 0;
      recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 38 : 0;
      write_len(ph == 2 ? 6'd32 : 6'($urandom_range(1, 8)));
      while (words_sent < 160 * (ph + 1)) begin
        if ($urandom_range(15) == 0) write_len(6'($urandom_range(63)));
        if ($urandom_range(30) == 0) begin
          stall_len = 300;
          stall_reqs++;
        end
        if ($urandom_range(20) == 0) drain();
        send_path($urandom_range(1, 9));
      end
    end

    // long stall on the result side while words keep coming
    stall_len = 400;
    stall_reqs++;
    send_path(12);
    drain();

    $display("sent %0d waypoint words, checked %0d curve samples", words_sent, samples_seen);
    $display("segment lengths from 1 to 32 including clamped register values");
    if (fail_count == 0 && pending_samples == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
